### sv/triangle_vertex_setup_core_macros.svh
// Assertion macros for the triangle vertex setup block.
// Used by the top level; no other dependencies.
`ifndef TRIANGLE_VERTEX_SETUP_CORE_MACROS_SVH
`define TRIANGLE_VERTEX_SETUP_CORE_MACROS_SVH

// same-cycle implication under reset
`define TVS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under reset
`define TVS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/tvs_pkg.sv
// Shared constants and types for the triangle vertex setup block.
// No dependencies.
package tvs_pkg;
  localparam int COORD_BITS_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int VP_BITS           = 14;
  localparam int AREA_BITS         = 64;
  localparam int APB_DATA_BITS     = 32;
  localparam int APB_ADDR_BITS     = 3;
  localparam logic [VP_BITS-1:0] VP_WIDTH_RST  = VP_BITS'(640);
  localparam logic [VP_BITS-1:0] VP_HEIGHT_RST = VP_BITS'(480);
  localparam logic REG_VP_WIDTH  = 1'b0;
  localparam logic REG_VP_HEIGHT = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage

### sv/tvs_divider.sv
// Restoring divider, one quotient bit per cycle: 2^(2*FRACTION_BITS) / divisor.
// Depends on tvs_pkg.
module tvs_divider #(
  parameter int COORD_BITS    = tvs_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = tvs_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [COORD_BITS-1:0]         divisor,
  output tvs_pkg::div_stat_t            stat,
  output logic [2*FRACTION_BITS:0]      quot
);
  import tvs_pkg::*;

  localparam int QW = 2 * FRACTION_BITS + 1;
  localparam int CW = $clog2(QW + 1);

  logic [COORD_BITS-1:0] rem_r, rem_nxt, d_r;
  logic [QW-1:0]         quo_r, quo_nxt, num_r;
  logic [CW-1:0]         cnt_r;
  logic                  busy_r, done_r;
  logic [COORD_BITS:0]   sh, diff;
  logic                  ge;

  always_comb begin
    sh      = {rem_r, num_r[QW-1]};
    diff    = sh - {1'b0, d_r};
    ge      = sh >= {1'b0, d_r};
    rem_nxt = ge ? diff[COORD_BITS-1:0] : sh[COORD_BITS-1:0];
    quo_nxt = {quo_r[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= divisor;
      rem_r <= '0;
      quo_r <= '0;
      num_r <= QW'(1) << (2 * FRACTION_BITS);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      num_r <= num_r << 1;
    end
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign quot = quo_r;
endmodule

### sv/tvs_mul.sv
// Shared signed multiplier with a registered product.
// Depends on tvs_pkg.
module tvs_mul #(
  parameter int COORD_BITS = tvs_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic signed [COORD_BITS:0]         a,
  input  logic signed [COORD_BITS:0]         b,
  output logic signed [2*COORD_BITS+1:0]     p_r
);
  import tvs_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule

### sv/triangle_vertex_setup_core.sv
// Triangle vertex setup: clip test, 1/w, viewport and depth mapping, triangle area and box.
// Depends on tvs_pkg, tvs_divider, tvs_mul and triangle_vertex_setup_core_macros.svh.
//
// A vertex request first gets the reciprocal of w from a bit-serial divider,
// then one shared multiplier forms x/w, y/w, z/w, both viewport products and
// both area products in turn. The block takes one vertex at a time and accepts
// no new request until it is through with the last; a finished result sits in
// an output register and the next vertex can be taken while it waits. Every
// third vertex closes a triangle and carries area, cull flag and bounding box;
// otherwise those fields are zero.
`include "triangle_vertex_setup_core_macros.svh"
module triangle_vertex_setup_core #(
  parameter int COORD_BITS    = tvs_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = tvs_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_BITS-1:0]        in_clip_x,
  input  logic signed [COORD_BITS-1:0]        in_clip_y,
  input  logic signed [COORD_BITS-1:0]        in_clip_z,
  input  logic signed [COORD_BITS-1:0]        in_clip_w,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_outside_clip,
  output logic signed [COORD_BITS-1:0]        out_screen_x,
  output logic signed [COORD_BITS-1:0]        out_screen_y,
  output logic signed [COORD_BITS-1:0]        out_depth,
  output logic signed [COORD_BITS-1:0]        out_recip_w,
  output logic                                out_triangle_done,
  output logic signed [tvs_pkg::AREA_BITS-1:0] out_area,
  output logic                                out_culled,
  output logic signed [COORD_BITS-1:0]        out_box_min_x,
  output logic signed [COORD_BITS-1:0]        out_box_min_y,
  output logic signed [COORD_BITS-1:0]        out_box_max_x,
  output logic signed [COORD_BITS-1:0]        out_box_max_y,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tvs_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [tvs_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [tvs_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready
);
  import tvs_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int F   = FRACTION_BITS;
  localparam int QW  = 2 * F + 1;
  localparam int MW  = C + 1;
  localparam int PW  = 2 * MW;
  localparam int SW  = ((PW > QW + 1) ? PW : QW + 1) + 1;
  localparam int AFW = PW + AREA_BITS + 2;

  localparam logic signed [SW-1:0] CMAX_W = {{(SW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN_W = -CMAX_W - SW'(1);
  localparam logic signed [AFW-1:0] AMAX_W = {{(AFW-AREA_BITS+1){1'b0}}, {(AREA_BITS-1){1'b1}}};
  localparam logic signed [AFW-1:0] AMIN_W = -AMAX_W - AFW'(1);
  localparam logic signed [MW-1:0] ONE_M = signed'(MW'(1) << F);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_DIV  = 11'b00000000010,
    S_MX   = 11'b00000000100,
    S_MY   = 11'b00000001000,
    S_MZ   = 11'b00000010000,
    S_SX   = 11'b00000100000,
    S_SY   = 11'b00000100000 << 1,
    S_A1   = 11'b00010000000,
    S_A2   = 11'b00100000000,
    S_A3   = 11'b01000000000,
    S_FIN  = 11'b10000000000
  } state_t;

  function automatic logic signed [C-1:0] sat_c(input logic signed [SW-1:0] v);
    logic signed [C-1:0] r;
    if (v > CMAX_W) r = CMAX_W[C-1:0];
    else if (v < CMIN_W) r = CMIN_W[C-1:0];
    else r = v[C-1:0];
    return r;
  endfunction

  state_t state_r, state_nxt;
  logic [VP_BITS-1:0] vp_w_r, vp_h_r;
  logic [1:0] corner_r;
  logic signed [C-1:0] x_r, y_r, z_r, w_r, inv_r, nx_r, ny_r, nz_r, sx_r, sy_r;
  logic signed [C-1:0] held_x_r [2];
  logic signed [C-1:0] held_y_r [2];
  logic signed [C-1:0] min_x_r, min_y_r, max_x_r, max_y_r;
  logic signed [PW-1:0] m1_r, p;
  logic signed [MW-1:0] ma, mb;
  div_stat_t div_stat;
  logic [QW-1:0] quot;
  logic div_start;
  logic [C-1:0] w_mag;
  logic signed [SW-1:0] q_s;
  logic signed [C-1:0] inv_nxt, sx_nxt, sy_nxt, dz;
  logic signed [AFW-1:0] area_w;
  logic signed [AREA_BITS-1:0] area_s;
  logic signed [MW-1:0] xe, ye, ze, we;
  logic outside;
  logic signed [C-1:0] bminx, bminy, bmaxx, bmaxy;
  logic out_valid_r;
  logic cfg_wr;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_VP_HEIGHT) ? APB_DATA_BITS'(vp_h_r) : APB_DATA_BITS'(vp_w_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_w_r <= VP_WIDTH_RST;
      vp_h_r <= VP_HEIGHT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_VP_WIDTH) vp_w_r <= pwdata[VP_BITS-1:0];
      else vp_h_r <= pwdata[VP_BITS-1:0];
    end
  end

  // ---------------- shared units ----------------
  assign w_mag     = w_r[C-1] ? C'(-w_r) : w_r;
  assign div_start = (state_r == S_IDLE) && in_valid;

  tvs_divider #(.COORD_BITS(C), .FRACTION_BITS(F)) u_div (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_DIV && !div_stat.busy && !div_stat.done),
    .divisor(w_mag), .stat(div_stat), .quot(quot)
  );

  tvs_mul #(.COORD_BITS(C)) u_mul (.clk(clk), .a(ma), .b(mb), .p_r(p));

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_MX: begin ma = MW'(x_r); mb = MW'(inv_r); end
      S_MY: begin ma = MW'(y_r); mb = MW'(inv_r); end
      S_MZ: begin ma = MW'(z_r); mb = MW'(inv_r); end
      S_SX: begin ma = MW'(nx_r) + ONE_M; mb = signed'(MW'(vp_w_r)); end
      S_SY: begin ma = MW'(ny_r) + ONE_M; mb = signed'(MW'(vp_h_r)); end
      S_A2: begin
        ma = MW'(sx_r) - MW'(held_x_r[0]);
        mb = MW'(held_y_r[1]) - MW'(held_y_r[0]);
      end
      // kept in S_FIN so the second area product holds while the output stalls
      S_A3, S_FIN: begin
        ma = MW'(sy_r) - MW'(held_y_r[0]);
        mb = MW'(held_x_r[1]) - MW'(held_x_r[0]);
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // ---------------- arithmetic around the units ----------------
  always_comb begin
    q_s     = signed'(SW'(quot));
    if (w_r[C-1]) q_s = -q_s;
    inv_nxt = (w_r == '0) ? CMAX_W[C-1:0] : sat_c(q_s);
    sx_nxt  = sat_c(SW'(p) >>> 1);
    sy_nxt  = sx_nxt;
    dz      = sat_c(SW'(MW'(nz_r) + ONE_M) >>> 1);
    area_w  = AFW'(m1_r) - AFW'(p);
    if (area_w > AMAX_W) area_s = AMAX_W[AREA_BITS-1:0];
    else if (area_w < AMIN_W) area_s = AMIN_W[AREA_BITS-1:0];
    else area_s = area_w[AREA_BITS-1:0];
    xe = MW'(x_r);
    ye = MW'(y_r);
    ze = MW'(z_r);
    we = MW'(w_r);
    outside = (xe < -we) || (xe > we) || (ye < -we) || (ye > we) || (ze < -we) || (ze > we);
    if (corner_r == 2'd0) begin
      bminx = sx_r; bmaxx = sx_r; bminy = sy_r; bmaxy = sy_r;
    end else begin
      bminx = (sx_r < min_x_r) ? sx_r : min_x_r;
      bmaxx = (sx_r > max_x_r) ? sx_r : max_x_r;
      bminy = (sy_r < min_y_r) ? sy_r : min_y_r;
      bmaxy = (sy_r > max_y_r) ? sy_r : max_y_r;
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DIV;
      S_DIV:  if (div_stat.done) state_nxt = S_MX;
      S_MX:   state_nxt = S_MY;
      S_MY:   state_nxt = S_MZ;
      S_MZ:   state_nxt = S_SX;
      S_SX:   state_nxt = S_SY;
      S_SY:   state_nxt = S_A1;
      S_A1:   state_nxt = S_A2;
      S_A2:   state_nxt = S_A3;
      S_A3:   state_nxt = S_FIN;
      S_FIN:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      corner_r    <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        corner_r    <= (corner_r == 2'd2) ? 2'd0 : corner_r + 2'd1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // the product of one state is registered in the state after it
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (div_start) begin
        x_r <= in_clip_x; y_r <= in_clip_y; z_r <= in_clip_z; w_r <= in_clip_w;
      end
      S_DIV:  if (div_stat.done) inv_r <= inv_nxt;
      S_MY:   nx_r <= sat_c(SW'(p) >>> F);
      S_MZ:   ny_r <= sat_c(SW'(p) >>> F);
      S_SX:   nz_r <= sat_c(SW'(p) >>> F);
      S_SY:   sx_r <= sx_nxt;
      S_A1:   sy_r <= sy_nxt;
      S_A3:   m1_r <= p;
      S_FIN: if (!out_valid_r || out_ready) begin
        min_x_r <= bminx; max_x_r <= bmaxx; min_y_r <= bminy; max_y_r <= bmaxy;
        if (corner_r != 2'd2) begin
          held_x_r[corner_r[0]] <= sx_r;
          held_y_r[corner_r[0]] <= sy_r;
        end
        out_outside_clip  <= outside;
        out_screen_x      <= sx_r;
        out_screen_y      <= sy_r;
        out_depth         <= dz;
        out_recip_w       <= inv_r;
        out_triangle_done <= (corner_r == 2'd2);
        out_area          <= (corner_r == 2'd2) ? area_s : '0;
        out_culled        <= (corner_r == 2'd2) && !area_s[AREA_BITS-1];
        out_box_min_x     <= (corner_r == 2'd2) ? bminx : '0;
        out_box_min_y     <= (corner_r == 2'd2) ? bminy : '0;
        out_box_max_x     <= (corner_r == 2'd2) ? bmaxx : '0;
        out_box_max_y     <= (corner_r == 2'd2) ? bmaxy : '0;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

  // ---------------- checks ----------------
  `TVS_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "ready high right after a request")
  `TVS_ASSERT_NOW(a_no_tri_fields, out_valid && !out_triangle_done, out_area == '0 && !out_culled, "triangle fields set without triangle")
  `TVS_ASSERT_NOW(a_cull_sign, out_valid && out_triangle_done, out_culled == !out_area[AREA_BITS-1], "cull flag disagrees with area sign")
  `TVS_ASSERT_NOW(a_corner_range, 1'b1, corner_r != 2'd3, "corner counter out of range")
endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for triangle_vertex_setup_core: vertex requests with random
// handshake gaps, APB viewport writes, and a built-in model of the vertex setup math.
// Depends on tvs_pkg and the RTL of triangle_vertex_setup_core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tvs_pkg::*;

  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam longint ONE_FX = 64'sd65536;
  localparam int RESULT_LATENCY = 44;

  typedef struct packed {
    logic        outside_clip;
    logic [31:0] screen_x;
    logic [31:0] screen_y;
    logic [31:0] depth;
    logic [31:0] recip_w;
    logic        triangle_done;
    logic [63:0] area;
    logic        culled;
    logic [31:0] box_min_x;
    logic [31:0] box_min_y;
    logic [31:0] box_max_x;
    logic [31:0] box_max_y;
  } vertex_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_clip_x = '0, in_clip_y = '0, in_clip_z = '0, in_clip_w = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_outside_clip, out_triangle_done, out_culled;
  // plain vectors so the checker compares raw bits
  logic [31:0] out_screen_x, out_screen_y, out_depth, out_recip_w;
  logic [31:0] out_box_min_x, out_box_min_y, out_box_max_x, out_box_max_y;
  logic [63:0] out_area;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;

  // model state
  logic [VP_BITS-1:0] vp_width = VP_WIDTH_RST;
  logic [VP_BITS-1:0] vp_height = VP_HEIGHT_RST;
  int corner_idx = 0;
  longint held_x[2], held_y[2];
  longint run_min_x, run_min_y, run_max_x, run_max_y;

  vertex_result_t pending_vertices[$];
  int error_count = 0;
  bit steady_in = 1'b0;
  bit steady_out = 1'b0;

  triangle_vertex_setup_core uut (.*);

  always #10 clk = ~clk;

  function automatic longint sat_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic vertex_result_t predict_vertex(logic signed [31:0] cx, logic signed [31:0] cy,
                                                    logic signed [31:0] cz, logic signed [31:0] cw);
    vertex_result_t r;
    longint x, y, z, w, inv, nx, ny, nz, sx, sy, dz;
    logic signed [129:0] ux, uy, vx, vy, xprod;
    x = cx; y = cy; z = cz; w = cw;
    r = '0;
    r.outside_clip = (x < -w) || (x > w) || (y < -w) || (y > w) || (z < -w) || (z > w);
    if (w == 0) inv = COORD_MAX;
    else inv = sat_coord((64'sd1 <<< 32) / w);
    nx = sat_coord((x * inv) >>> 16);
    ny = sat_coord((y * inv) >>> 16);
    nz = sat_coord((z * inv) >>> 16);
    sx = sat_coord(((nx + ONE_FX) * longint'({50'd0, vp_width})) >>> 1);
    sy = sat_coord(((ny + ONE_FX) * longint'({50'd0, vp_height})) >>> 1);
    dz = sat_coord((nz + ONE_FX) >>> 1);
    if (corner_idx == 0) begin
      run_min_x = sx; run_max_x = sx;
      run_min_y = sy; run_max_y = sy;
    end else begin
      if (sx < run_min_x) run_min_x = sx;
      if (sy < run_min_y) run_min_y = sy;
      if (sx > run_max_x) run_max_x = sx;
      if (sy > run_max_y) run_max_y = sy;
    end
    if (corner_idx == 2) begin
      ux = sx - held_x[0];
      uy = sy - held_y[0];
      vx = held_x[1] - held_x[0];
      vy = held_y[1] - held_y[0];
      xprod = ux * vy - uy * vx;
      if (xprod > 130'sd9223372036854775807) xprod = 130'sd9223372036854775807;
      if (xprod < -130'sd9223372036854775808) xprod = -130'sd9223372036854775808;
      r.area = xprod[63:0];
      r.culled = !xprod[129];
      r.triangle_done = 1'b1;
      r.box_min_x = run_min_x[31:0];
      r.box_min_y = run_min_y[31:0];
      r.box_max_x = run_max_x[31:0];
      r.box_max_y = run_max_y[31:0];
      corner_idx = 0;
    end else begin
      held_x[corner_idx] = sx;
      held_y[corner_idx] = sy;
      corner_idx++;
    end
    r.screen_x = sx[31:0];
    r.screen_y = sy[31:0];
    r.depth = dz[31:0];
    r.recip_w = inv[31:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s expected %h actual %h", $realtime, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    vertex_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_vertices.size() == 0) begin
        $display("%0t unexpected result, screen_x actual %h", $realtime, out_screen_x);
        error_count++;
      end else begin
        e = pending_vertices.pop_front();
        check_field("outside_clip", e.outside_clip, out_outside_clip);
        check_field("screen_x", e.screen_x, out_screen_x);
        check_field("screen_y", e.screen_y, out_screen_y);
        check_field("depth", e.depth, out_depth);
        check_field("recip_w", e.recip_w, out_recip_w);
        check_field("triangle_done", e.triangle_done, out_triangle_done);
        check_field("area", e.area, out_area);
        check_field("culled", e.culled, out_culled);
        check_field("box_min_x", e.box_min_x, out_box_min_x);
        check_field("box_min_y", e.box_min_y, out_box_min_y);
        check_field("box_max_x", e.box_max_x, out_box_max_x);
        check_field("box_max_y", e.box_max_y, out_box_max_y);
      end
    end
  end

  // result-side stalls
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = steady_out ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        @(negedge clk) out_ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_clip_x = x; in_clip_y = y; in_clip_z = z; in_clip_w = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_vertices.push_back(predict_vertex(x, y, z, w));
  endtask

  // wait until every vertex request has produced its result
  task automatic drain();
    @(negedge clk) in_valid = 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_viewport(logic reg_sel, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {reg_sel, 2'b00}; pwdata = value;
    @(negedge clk) penable = 1'b1;
    @(posedge clk);
    if (reg_sel == REG_VP_WIDTH) vp_width = value[VP_BITS-1:0];
    else vp_height = value[VP_BITS-1:0];
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = {reg_sel, 2'b00};
    @(negedge clk) psel = 1'b1;
    @(negedge clk) penable = 1'b1;
    @(posedge clk);
    check_field("prdata", {50'd0, (reg_sel == REG_VP_WIDTH) ? vp_width : vp_height},
                {32'd0, prdata});
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  // mostly in-frustum vertices, some with random bits, some with tiny w
  task automatic send_random_vertex();
    int mode;
    logic signed [31:0] w, x, y, z;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      w = $urandom_range(32'h8000, 32'h0064_0000);
      if ($urandom_range(0, 5) == 0) w = -w;
      x = $urandom_range(0, 2 * (w < 0 ? -w : w)) - (w < 0 ? -w : w);
      y = $urandom_range(0, 2 * (w < 0 ? -w : w)) - (w < 0 ? -w : w);
      z = $urandom_range(0, 2 * (w < 0 ? -w : w)) - (w < 0 ? -w : w);
    end else if (mode < 8) begin
      w = $urandom; x = $urandom; y = $urandom; z = $urandom;
    end else begin
      w = $urandom_range(0, 64) - 32;
      x = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      y = $urandom; z = $urandom_range(0, 255) - 128;
    end
    send_vertex(x, y, z, w);
  endtask

  task automatic test_directed_vertices();
    send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    send_vertex(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    send_vertex(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
    send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    send_vertex(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
    send_vertex(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    // zero w, tiny w, extreme w
    send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000);
    send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
    send_vertex(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0002);
    // degenerate triangle and outside-clip corners
    send_vertex(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000);
    send_vertex(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000);
    send_vertex(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000);
    send_vertex(32'h0002_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    send_vertex(32'h0000_0000, 32'hFFFD_0000, 32'h0000_0000, 32'h0001_0000);
    send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0005_0000, 32'hFFFF_0000);
    drain();
  endtask

  task automatic test_viewport_extremes();
    logic [31:0] sizes[6] = '{32'd0, 32'd1, 32'd8192, 32'hFFFF_FFFF, 32'd1920, 32'd2};
    for (int i = 0; i < 6; i++) begin
      write_viewport(REG_VP_WIDTH, sizes[i]);
      write_viewport(REG_VP_HEIGHT, sizes[5 - i] | ($urandom & 32'hFFFF_C000));
      for (int k = 0; k < 12; k++) send_random_vertex();
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
      send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
      drain();
    end
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 8; phase++) begin
      steady_in = (phase == 2);
      steady_out = (phase == 2) || (phase == 5);
      write_viewport(REG_VP_WIDTH, $urandom_range(1, 8192));
      write_viewport(REG_VP_HEIGHT, $urandom_range(1, 8192));
      for (int k = 0; k < 80; k++) send_random_vertex();
      drain();
      steady_in = 1'b0;
      steady_out = 1'b0;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    test_directed_vertices();
    test_viewport_extremes();
    test_random_stream();
    drain();
    repeat (RESULT_LATENCY + 20) @(posedge clk);
    if (error_count == 0 && pending_vertices.size() == 0)
      $display("triangle_vertex_setup_core: match");
    else
      $display("triangle_vertex_setup_core: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("triangle_vertex_setup_core: mismatch");
    $finish;
  end
endmodule
